// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SMSV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked at the next clock edge.
`define SMSV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smsv_pkg.sv =====
// ----------------------------------------------------------------------------
// smsv_pkg
// Types and constants shared by the segmented Mobius sieve modules.
// ----------------------------------------------------------------------------
package smsv_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_SIEVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_BAD  = 2'b10;

    localparam int MAX_SEGMENT = 1 << 22;

    // One sieve entry as held in the entry memory.
    typedef struct packed {
        logic [1:0]  sign;
        logic [63:0] prod;
        logic [31:0] fac;
    } t_entry;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
        logic [63:0] remainder;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_SQ,
        S_CHECK,
        S_DIV1,
        S_DIV2,
        S_P_CHK,
        S_P_RD,
        S_P_LO,
        S_P_HI,
        S_P_WR,
        S_Q_START,
        S_Q_CHK,
        S_Q_RD,
        S_Q_WR,
        S_R_RD,
        S_R_CHK,
        S_R_EVAL,
        S_R_DIV,
        S_DONE
    } t_state;

endpackage

// ===== hdl/smsv_ram.sv =====
// ----------------------------------------------------------------------------
// smsv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smsv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/smsv_div.sv =====
// ----------------------------------------------------------------------------
// smsv_div
// Restoring 64-by-64-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smsv_div
    import smsv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dvs;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        take;

    assign trial = {r_rem, r_quo[63]};
    assign diff  = trial - {1'b0, r_dvs};
    assign take  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= take ? diff[63:0] : trial[63:0];
            r_quo <= {r_quo[62:0], take};
        end else if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== hdl/segmented_mobius_sieve_unit.sv =====
// ----------------------------------------------------------------------------
// segmented_mobius_sieve_unit
// Sieves one segment of integers for the Mobius function and largest factor.
// ----------------------------------------------------------------------------
// The unit holds one entry (sign, product of sieved primes, last prime) for
// each offset of a segment that starts at segment_base, in a single memory of
// SEGMENT_SIZE words. A clear transaction writes every entry. A sieve
// transaction squares the prime on the shared 32x32 multiplier, then runs
// the divider twice to find the first multiple of p and of p squared in the
// segment; each multiple of p is then read, multiplied as two partial
// products and written back, and each multiple of p squared is read and
// written back with a zero sign. A sieve whose square reaches an unwrapped
// segment end, or whose prime is below two, leaves the segment untouched. A
// read transaction runs the divider only when a cofactor remains and must
// be found. Items are taken one at a time: the input stalls until the
// current transaction has moved its result into the output register, which
// then waits for the sink on its own while the next transaction is accepted.
// The memory needs no clearing after reset; reading an entry that no clear
// has written returns unspecified data. Registers are written over the APB
// port at byte address 0 (segment_base) and 8 (segment_length); only address
// bit 3 selects the register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segmented_mobius_sieve_unit
    import smsv_pkg::*;
#(
    parameter int SEGMENT_SIZE = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic [31:0]       i_prime_value,
    input  logic [11:0]       i_entry_index,
    // Output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_result_kind,
    output logic              o_prime_ignored,
    output logic [11:0]       o_read_index,
    output logic signed [1:0] o_mobius_value,
    output logic [63:0]       o_largest_factor,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    localparam int AW     = (SEGMENT_SIZE > 1) ? $clog2(SEGMENT_SIZE) : 1;
    localparam int LIVE_W = $clog2(SEGMENT_SIZE + 1);
    localparam int EW     = $bits(t_entry);

    // Configuration registers.
    logic [63:0] r_base;
    logic [12:0] r_len;

    // Control.
    t_state r_state, n_state;
    logic   r_out_valid;

    // Working registers.
    logic [1:0]    r_cmd,  n_cmd;
    logic [31:0]   r_p,    n_p;
    logic [11:0]   r_idx,  n_idx;
    logic [63:0]   r_i,    n_i;
    logic [63:0]   r_sq,   n_sq;
    logic [63:0]   r_st2,  n_st2;
    logic [63:0]   r_mlo,  n_mlo;
    logic [63:0]   r_mul;
    logic [63:0]   r_m,    n_m;
    logic [AW-1:0] r_clr,  n_clr;
    t_entry        r_ent,  n_ent;
    logic          r_ign,  n_ign;
    logic [1:0]    r_mu,   n_mu;
    logic [63:0]   r_fac,  n_fac;

    // Output payload.
    logic [1:0]  r_o_kind;
    logic        r_o_ign;
    logic [11:0] r_o_idx;
    logic [1:0]  r_o_mu;
    logic [63:0] r_o_fac;

    logic        in_acc;
    logic        out_load;
    logic        cfg_wr;

    logic [LIVE_W-1:0] len_live;
    logic [63:0]       len64;
    logic [64:0]       seg_end;
    logic [64:0]       i_next;
    logic [31:0]       mul_a;
    logic [63:0]       mul_full;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;
    logic [EW-1:0] ram_rbits;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == REG_LEN) ? {51'd0, r_len} : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_len  <= 13'd4096;
        end else if (cfg_wr) begin
            case (paddr[3])
                REG_BASE: r_base <= pwdata;
                REG_LEN:  r_len  <= pwdata[12:0];
                default:  r_base <= r_base;
            endcase
        end
    end

    // Live length saturates at the memory depth.
    assign len_live = (32'(r_len) > 32'(SEGMENT_SIZE)) ? LIVE_W'(SEGMENT_SIZE)
                                                       : LIVE_W'(r_len);
    assign len64    = 64'(len_live);
    assign seg_end  = {1'b0, r_base} + {1'b0, len64};

    // ------------------------------------------------------------------
    // Entry memory and divider
    // ------------------------------------------------------------------
    smsv_ram #(
        .WIDTH (EW),
        .DEPTH (SEGMENT_SIZE),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );
    assign ram_rdata = t_entry'(ram_rbits);

    smsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // The shared multiplier squares the prime and forms the two partial
    // products of the 64-bit entry product.
    always_comb begin
        case (r_state)
            S_P_LO:  mul_a = ram_rdata.prod[31:0];
            S_P_HI:  mul_a = r_ent.prod[63:32];
            default: mul_a = r_p;
        endcase
    end
    assign mul_full = mul_a * r_p;

    // The walk step is p in the first pass and p squared in the second.
    assign i_next = {1'b0, r_i} + ((r_state == S_Q_WR) ? {1'b0, r_sq} : {33'd0, r_p});

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_p     = r_p;
        n_idx   = r_idx;
        n_i     = r_i;
        n_sq    = r_sq;
        n_st2   = r_st2;
        n_mlo   = r_mlo;
        n_m     = r_m;
        n_clr   = r_clr;
        n_ent   = r_ent;
        n_ign   = r_ign;
        n_mu    = r_mu;
        n_fac   = r_fac;

        ram_we    = 1'b0;
        ram_waddr = r_i[AW-1:0];
        ram_raddr = r_i[AW-1:0];
        ram_wdata = r_ent;

        div_req.start    = 1'b0;
        div_req.dividend = r_base;
        div_req.divisor  = {32'd0, r_p};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd = i_command;
                    n_p   = i_prime_value;
                    n_idx = i_entry_index;
                    n_clr = '0;
                    n_ign = 1'b0;
                    n_mu  = SIGN_ZERO;
                    n_fac = '0;
                    case (i_command)
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_SIEVE: n_state = S_SQ;
                        CMD_READ:  n_state = S_R_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end

            S_CLEAR: begin
                ram_we         = 1'b1;
                ram_waddr      = r_clr;
                ram_wdata.sign = SIGN_POS;
                ram_wdata.prod = 64'd1;
                ram_wdata.fac  = 32'd1;
                n_clr          = r_clr + AW'(1);
                if (r_clr == AW'(SEGMENT_SIZE - 1)) begin
                    n_state = S_DONE;
                end
            end

            S_SQ: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                n_sq = r_mul;
                // A prime below two, or one whose square reaches an end that
                // did not wrap, leaves the segment untouched.
                if (r_p < 32'd2 || (!seg_end[64] && r_mul >= seg_end[63:0])) begin
                    n_ign   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV1;
                end
            end

            S_DIV1: begin
                if (div_rsp.done) begin
                    n_i = (div_rsp.remainder == 64'd0) ? 64'd0
                                                       : {32'd0, r_p} - div_rsp.remainder;
                    div_req.start   = 1'b1;
                    div_req.divisor = r_sq;
                    n_state         = S_DIV2;
                end
            end

            S_DIV2: begin
                if (div_rsp.done) begin
                    n_st2   = (div_rsp.remainder == 64'd0) ? 64'd0
                                                           : r_sq - div_rsp.remainder;
                    n_state = S_P_CHK;
                end
            end

            S_P_CHK: begin
                n_state = (r_i < len64) ? S_P_RD : S_Q_START;
            end

            S_P_RD: begin
                n_state = S_P_LO;
            end

            S_P_LO: begin
                n_ent   = ram_rdata;
                n_state = S_P_HI;
            end

            S_P_HI: begin
                n_mlo   = r_mul;
                n_state = S_P_WR;
            end

            S_P_WR: begin
                ram_we         = 1'b1;
                ram_wdata.sign = 2'(~r_ent.sign + 2'd1);
                ram_wdata.prod = r_mlo + {r_mul[31:0], 32'd0};
                ram_wdata.fac  = r_p;
                n_i            = i_next[63:0];
                n_state        = (!i_next[64] && i_next[63:0] < len64) ? S_P_RD : S_Q_START;
            end

            S_Q_START: begin
                n_i     = r_st2;
                n_state = S_Q_CHK;
            end

            S_Q_CHK: begin
                n_state = (r_i < len64) ? S_Q_RD : S_DONE;
            end

            S_Q_RD: begin
                n_state = S_Q_WR;
            end

            S_Q_WR: begin
                ram_we         = 1'b1;
                ram_wdata      = ram_rdata;
                ram_wdata.sign = SIGN_ZERO;
                n_i            = i_next[63:0];
                n_state        = (!i_next[64] && i_next[63:0] < len64) ? S_Q_RD : S_DONE;
            end

            S_R_RD: begin
                ram_raddr = AW'(r_idx);
                n_state   = (32'(r_idx) < 32'(SEGMENT_SIZE)) ? S_R_CHK : S_DONE;
            end

            S_R_CHK: begin
                n_ent   = ram_rdata;
                n_m     = r_base + 64'(r_idx);
                n_state = S_R_EVAL;
            end

            S_R_EVAL: begin
                if (r_ent.sign == SIGN_ZERO) begin
                    n_state = S_DONE;
                end else if (r_ent.prod != 64'd0 && r_ent.prod != r_m) begin
                    // A cofactor remains: it is one more prime.
                    div_req.start    = 1'b1;
                    div_req.dividend = r_m;
                    div_req.divisor  = r_ent.prod;
                    n_state          = S_R_DIV;
                end else begin
                    n_mu    = r_ent.sign;
                    n_fac   = {32'd0, r_ent.fac};
                    n_state = S_DONE;
                end
            end

            S_R_DIV: begin
                if (div_rsp.done) begin
                    n_mu    = 2'(~r_ent.sign + 2'd1);
                    n_fac   = (div_rsp.quotient > {32'd0, r_ent.fac}) ? div_rsp.quotient
                                                                      : {32'd0, r_ent.fac};
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_p   <= n_p;
        r_idx <= n_idx;
        r_i   <= n_i;
        r_sq  <= n_sq;
        r_st2 <= n_st2;
        r_mlo <= n_mlo;
        r_mul <= mul_full;
        r_m   <= n_m;
        r_clr <= n_clr;
        r_ent <= n_ent;
        r_ign <= n_ign;
        r_mu  <= n_mu;
        r_fac <= n_fac;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_kind <= r_cmd;
            r_o_ign  <= (r_cmd == CMD_SIEVE) ? r_ign : 1'b0;
            r_o_idx  <= (r_cmd == CMD_READ) ? r_idx : 12'd0;
            r_o_mu   <= (r_cmd == CMD_READ) ? r_mu : SIGN_ZERO;
            r_o_fac  <= (r_cmd == CMD_READ) ? r_fac : 64'd0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_o_kind;
    assign o_prime_ignored  = r_o_ign;
    assign o_read_index     = r_o_idx;
    assign o_mobius_value   = r_o_mu;
    assign o_largest_factor = r_o_fac;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SMSV_ASSERT_IMP(a_div_idle_on_start, div_req.start, !div_rsp.busy,
        "divider started while busy")
    `SMSV_ASSERT_IMP(a_walk_in_range, (r_state == S_P_WR) || (r_state == S_Q_WR),
        r_i < len64, "sieve write outside live segment")
    `SMSV_ASSERT_NXT(a_nop_no_work, in_acc && (i_command == CMD_NOP),
        r_state == S_IDLE, "ignored command started work")
    `SMSV_ASSERT_IMP(a_mobius_legal, o_out_valid, o_mobius_value != SIGN_BAD,
        "illegal Mobius value")

    // Keeps the elaboration-time bound on the segment size visible.
    `SMSV_ASSERT_IMP(a_size_bound, 1'b1, SEGMENT_SIZE <= MAX_SEGMENT,
        "segment size beyond limit")

endmodule

// ===== sim/segmented_mobius_sieve_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segmented_mobius_sieve_unit_tb
// Self-checking bench for the segmented Mobius sieve unit.
// ----------------------------------------------------------------------------
// A short directed table runs first, right after reset. Then a series of
// phases follows. Each phase programs a new segment and an idling pattern,
// clears the segment, and sends random commands. Most of these commands sieve
// with small primes in ascending order and read back entries. Every accepted
// transaction but a no-op is run through a behavioral copy of the sieve,
// and each result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module segmented_mobius_sieve_unit_tb
    import smsv_pkg::*;
;

    localparam int         SEG          = 4096;
    localparam logic [3:0] ADDR_BASE    = 4'd0;
    localparam logic [3:0] ADDR_LEN     = 4'd8;
    localparam int         SETTLE_CYC   = 200;
    localparam int         PHASES       = 12;
    localparam int         PHASE_ITEMS  = 105;

    typedef struct {
        logic [1:0]  kind;
        logic        ign;
        logic [11:0] idx;
        logic [1:0]  mu;
        logic [63:0] fac;
    } t_sieve_result;

    typedef struct {
        logic [1:0]    cmd;
        logic [31:0]   prime;
        logic [11:0]   idx;
        bit            typed;
        t_sieve_result res;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_command = CMD_CLEAR;
    logic [31:0]       i_prime_value = '0;
    logic [11:0]       i_entry_index = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_result_kind;
    logic              o_prime_ignored;
    logic [11:0]       o_read_index;
    logic signed [1:0] o_mobius_value;
    logic [63:0]       o_largest_factor;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;

    segmented_mobius_sieve_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_prime_value    (i_prime_value),
        .i_entry_index    (i_entry_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_prime_ignored  (o_prime_ignored),
        .o_read_index     (o_read_index),
        .o_mobius_value   (o_mobius_value),
        .o_largest_factor (o_largest_factor),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 8 ns clock: 4 ns high, 4 ns low.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the unit hangs; far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the sieve. It holds its own segment registers and its
    // own entry arrays, updated in the order the unit accepts transactions.
    // ------------------------------------------------------------------------
    logic [63:0] seg_base = '0;
    logic [12:0] seg_len = 13'd4096;
    int          entry_sign [SEG];
    logic [63:0] entry_prod [SEG];
    logic [31:0] entry_fac  [SEG];

    t_sieve_result expected_results[$];
    bit            failed = 1'b0;
    int            send_gap_pct = 0;
    int            stall_pct = 0;
    int unsigned   small_primes[$];

    function automatic logic [63:0] live_length();
        return (seg_len > SEG) ? 64'(SEG) : 64'(seg_len);
    endfunction

    function automatic void clear_entries();
        for (int k = 0; k < SEG; k++) begin
            entry_sign[k] = 1;
            entry_prod[k] = 64'd1;
            entry_fac[k]  = 32'd1;
        end
    endfunction

    // Marks the multiples of p and of p squared. Returns 1 when the prime is
    // skipped: p below 2, or p squared at or past an unwrapped segment end.
    function automatic bit sieve_multiples(logic [63:0] p);
        logic [63:0] len;
        logic [63:0] seg_end;
        logic [63:0] sq;
        logic [63:0] k;
        len     = live_length();
        seg_end = seg_base + len;
        if (p < 2)
            return 1'b1;
        sq = p * p;
        if (!(seg_end < seg_base) && sq >= seg_end)
            return 1'b1;
        for (k = (p - seg_base % p) % p; k < len; k += p) begin
            entry_sign[k] = -entry_sign[k];
            entry_prod[k] = entry_prod[k] * p;
            entry_fac[k]  = p[31:0];
        end
        for (k = (sq - seg_base % sq) % sq; k < len; k += sq)
            entry_sign[k] = 0;
        return 1'b0;
    endfunction

    function automatic t_sieve_result predict_result(logic [1:0] cmd, logic [31:0] p,
                                                     logic [11:0] idx);
        t_sieve_result r;
        logic [63:0]   m;
        logic [63:0]   prod;
        logic [63:0]   q;
        int            s;
        r = '{kind: cmd, ign: 1'b0, idx: '0, mu: '0, fac: '0};
        case (cmd)
            CMD_CLEAR: clear_entries();
            CMD_SIEVE: r.ign = sieve_multiples({32'd0, p});
            default: begin
                r.idx = idx;
                s = entry_sign[idx];
                if (s != 0) begin
                    m    = seg_base + idx;
                    prod = entry_prod[idx];
                    q    = {32'd0, entry_fac[idx]};
                    // Whatever the sieved primes leave over is one more prime:
                    // it flips the sign and may be the largest factor.
                    if (prod != 0 && prod != m) begin
                        s = -s;
                        if (m / prod > q)
                            q = m / prod;
                    end
                    r.mu  = s[1:0];
                    r.fac = q;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. The payload goes out at a rising edge and stays put until
    // the edge at which the unit takes it. Valid stays high from one
    // transaction to the next unless the sender idles.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [1:0] cmd, logic [31:0] p, logic [11:0] idx,
                             bit typed, t_sieve_result typed_res);
        t_sieve_result pr;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_prime_value <= p;
        i_entry_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        // A no-op command returns nothing and leaves the entries alone.
        if (cmd != CMD_NOP) begin
            pr = predict_result(cmd, p, idx);
            expected_results.push_back(typed ? typed_res : pr);
        end
    endtask

    // Lets every outstanding result come back, then waits out SETTLE_CYC in case
    // a no-op is still in flight.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // APB write, setup then access phase; the register takes the data at the access edge.
    task automatic write_reg(logic [3:0] addr, logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_BASE)
            seg_base = data;
        else
            seg_len = data[12:0];
    endtask

    // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both, lightly.
    task automatic set_idling(int mode);
        case (mode)
            1:       begin send_gap_pct = 68; stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  stall_pct = 68; end
            3:       begin send_gap_pct = 6;  stall_pct = 6;  end
            default: begin send_gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Output side: check each accepted result against the oldest prediction,
    // then pick the stall for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sieve_result e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no transaction pending: kind %0d", o_result_kind);
                    failed <= 1'b1;
                end else begin
                    e = expected_results.pop_front();
                    if (o_result_kind !== e.kind) begin
                        $error("result_kind: expected %0d, got %0d", e.kind, o_result_kind);
                        failed <= 1'b1;
                    end
                    if (o_prime_ignored !== e.ign) begin
                        $error("prime_ignored: expected %0d, got %0d", e.ign, o_prime_ignored);
                        failed <= 1'b1;
                    end
                    if (o_read_index !== e.idx) begin
                        $error("read_index: expected %0d, got %0d", e.idx, o_read_index);
                        failed <= 1'b1;
                    end
                    if (o_mobius_value !== e.mu) begin
                        $error("mobius_value: expected %0d, got %0d",
                               $signed(e.mu), o_mobius_value);
                        failed <= 1'b1;
                    end
                    if (o_largest_factor !== e.fac) begin
                        $error("largest_factor: expected %0d, got %0d", e.fac,
                               o_largest_factor);
                        failed <= 1'b1;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. It runs on the reset segment (base 0, 4096 entries), so
    // primes up to 63 are live and 64 is the first value skipped. Rows with
    // typed set carry a result that follows directly from the rules; the rest
    // are left to the predictor.
    // ------------------------------------------------------------------------
    t_stim_row directed_rows[] = '{
        '{CMD_CLEAR, 32'd0,          12'd0,    1'b1, '{CMD_CLEAR, 1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd0,          12'd0,    1'b1, '{CMD_SIEVE, 1'b1, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd1,          12'd0,    1'b1, '{CMD_SIEVE, 1'b1, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'hFFFF_FFFF,  12'd0,    1'b1, '{CMD_SIEVE, 1'b1, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd64,         12'd0,    1'b1, '{CMD_SIEVE, 1'b1, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'd0,    1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'd7,    1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd2,          12'd0,    1'b0, '{CMD_SIEVE, 1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd3,          12'd0,    1'b0, '{CMD_SIEVE, 1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd5,          12'd0,    1'b0, '{CMD_SIEVE, 1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd4,          12'd0,    1'b0, '{CMD_SIEVE, 1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd7,          12'd0,    1'b0, '{CMD_SIEVE, 1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_SIEVE, 32'd61,         12'd0,    1'b0, '{CMD_SIEVE, 1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_NOP,   32'hFFFF_FFFF,  12'hFFF,  1'b0, '{CMD_NOP,   1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'd0,    1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'd1,    1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'd30,   1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'd60,   1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'd3721, 1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'd4093, 1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}},
        '{CMD_READ,  32'd0,          12'hFFF,  1'b0, '{CMD_READ,  1'b0, 12'd0, 2'd0, 64'd0}}
    };

    initial begin
        logic [63:0]   base_val;
        logic [12:0]   len_val;
        logic [63:0]   live;
        logic [31:0]   p;
        logic [11:0]   idx;
        int            pick;
        int            sent;
        int            next_prime;
        bit            is_prime;
        t_sieve_result none;

        none = '{kind: '0, ign: 1'b0, idx: '0, mu: '0, fac: '0};
        for (int n = 2; n < 400; n++) begin
            is_prime = 1'b1;
            for (int d = 2; d * d <= n; d++)
                if (n % d == 0)
                    is_prime = 1'b0;
            if (is_prime)
                small_primes.push_back(n);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0);
        foreach (directed_rows[r])
            send_item(directed_rows[r].cmd, directed_rows[r].prime, directed_rows[r].idx,
                      directed_rows[r].typed, directed_rows[r].res);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            // The first phases cover the segment extremes: an end that wraps
            // past 2^64, an empty segment, a length that saturates, and a
            // single entry. The rest use short segments at random bases.
            case (ph)
                0: begin base_val = 64'hFFFF_FFFF_FFFF_FFCE; len_val = 13'd4096; end
                1: begin base_val = '1; len_val = 13'd0; end
                2: begin base_val = '0; len_val = 13'h1FFF; end
                3: begin base_val = {$urandom, $urandom}; len_val = 13'd1; end
                default: begin
                    base_val = (ph % 3 == 0) ? {$urandom, $urandom}
                                             : 64'($urandom_range(100000));
                    len_val  = 13'($urandom_range(1, 128));
                end
            endcase
            write_reg(ADDR_BASE, base_val);
            write_reg(ADDR_LEN, {51'd0, len_val});
            set_idling(ph % 4);
            live = live_length();

            send_item(CMD_CLEAR, $urandom, 12'($urandom), 1'b0, none);
            next_prime = 0;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                p    = $urandom;
                idx  = 12'($urandom);
                if (pick < 2) begin
                    send_item(CMD_CLEAR, p, idx, 1'b0, none);
                    next_prime = 0;
                    sent++;
                end else if (pick < 5) begin
                    send_item(CMD_NOP, p, idx, 1'b0, none);
                end else if (pick < 50) begin
                    // Well-formed sieving: primes in ascending order.
                    if (next_prime < small_primes.size())
                        p = small_primes[next_prime++];
                    else
                        p = $urandom_range(2, 400);
                    send_item(CMD_SIEVE, p, idx, 1'b0, none);
                    sent++;
                end else if (pick < 56) begin
                    // Noise: 0, 1, composites, or any 32-bit value.
                    case ($urandom_range(3))
                        0: p = 32'($urandom_range(1));
                        1: p = small_primes[$urandom_range(10)]
                               * small_primes[$urandom_range(10)];
                        default: p = $urandom;
                    endcase
                    send_item(CMD_SIEVE, p, idx, 1'b0, none);
                    sent++;
                end else begin
                    if (live != 0 && $urandom_range(3) != 0)
                        idx = 12'($urandom_range(32'(live) - 1));
                    send_item(CMD_READ, p, idx, 1'b0, none);
                    sent++;
                end
            end
            drain();
        end

        if (!failed && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
